[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl of the ntc temperature block
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/ntcabt_pkg.sv]
// package of the ntc averaging and beta temperature block
// types, register indexes and fixed-point constants; no dependencies
`timescale 1ns / 1ps

package ntcabt_pkg;

    localparam int FULL_SCALE      = 4095;
    localparam int MV_SCALE        = 3300;
    localparam int T0_CENTI_K      = 29815;
    localparam int ZERO_C_CENTI_K  = 27315;
    localparam int TEMP_MAX        = 32767;
    localparam longint LN2_Q32     = 64'd2977044472;
    localparam int SCALE_Q16_X100  = 6553600;
    localparam int DIV_STEPS       = 53;
    localparam int LOG_FRAC_BITS   = 16;

    typedef enum logic [3:0] {
        CFG_SAMPLE_COUNT = 4'd0,
        CFG_SERIES_OHMS  = 4'd1,
        CFG_NOMINAL_OHMS = 4'd2,
        CFG_BETA_KELVIN  = 4'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_MV_LOAD,
        ST_DIV_MV,
        ST_CHECK,
        ST_LOG_LOAD,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_ACC,
        ST_LN,
        ST_MUL_A,
        ST_MUL_B,
        ST_DEN,
        ST_T_LOAD,
        ST_DIV_T,
        ST_T_FIN,
        ST_DONE
    } t_state;

endpackage

[rtl/core/ntc_average_beta_temperature.sv]
// top level of the ntc averaging and beta-equation temperature block
// depends on ntcabt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - input channel: i_in_valid / o_in_stall carry one converter word; conv_value >> 3
//   is added to the batch sum. a word that does not close the batch is taken without a stall
// - when sample_count words have been summed the batch closes and a sequencer works
//   out the mean and the temperature through one shared restoring divider (53 steps),
//   the millivolts by a reciprocal estimate and at most one correction step, one
//   squaring multiplier for the q16 log2 and a few multiplies
// - a closing word takes less work when the mean is out of range, as the log2 and the
//   temperature division are skipped; otherwise the two divider passes and the bit-serial
//   log2 of four operands (normalise shifts plus 16 squarings each) make up the work
// - o_in_stall is high for the whole of that work
// - output channel: o_out_valid / i_out_stall carry one result word from an output
//   register; new words are taken while it waits, and the block holds only at the
//   end of a batch if the previous result has still not been taken
// - config port: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data, always
//   ready; write only while idle. indexes above 3 are ignored
// - reset (i_rst_n low, synchronous) restores register defaults, clears the batch
//   sum and count and drops o_out_valid
module ntc_average_beta_temperature (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_conv_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [12:0]        o_average_raw,
    output logic [12:0]        o_millivolts,
    output logic signed [15:0] o_temp_centi_c,
    output logic               o_temp_valid,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    // configuration registers
    logic [7:0]  r_count;
    logic [19:0] r_series;
    logic [19:0] r_nominal;
    logic [13:0] r_beta;

    // batch state
    logic [20:0] r_sum;
    logic [7:0]  r_taken;

    ntcabt_pkg::t_state r_state, n_state;

    // shared divider: dividend shifts out at the top, quotient bits enter at the bottom
    logic [52:0] r_dvd;
    logic [37:0] r_rem;
    logic [37:0] r_dsr;
    logic [5:0]  r_cnt;

    // log2 unit
    logic [31:0] r_z;
    logic [4:0]  r_p;
    logic [15:0] r_frac;
    logic [1:0]  r_lsel;

    logic [12:0]        r_avg;
    logic [12:0]        r_mv;
    logic               r_tvalid;
    logic signed [15:0] r_temp;
    logic signed [23:0] r_s;
    logic signed [23:0] r_lq;
    logic [37:0]        r_pa;
    logic [28:0]        r_pb;
    logic signed [39:0] r_pc;
    logic [51:0]        r_num;
    logic signed [39:0] r_den;

    // output register
    logic               r_out_valid;
    logic [12:0]        r_o_avg;
    logic [12:0]        r_o_mv;
    logic signed [15:0] r_o_temp;
    logic               r_o_tvalid;

    logic        w_in_acc;
    logic        w_cfg_wr;
    logic [20:0] w_sum_next;
    logic [8:0]  w_n;
    logic [7:0]  w_count;
    logic        w_close;
    logic [38:0] w_rem2;
    logic [38:0] w_remsub;
    logic        w_ge;
    logic [12:0] w_avg;
    logic [24:0] w_mv_prod;
    logic [24:0] w_mv_est;
    logic [24:0] w_mv_rem;
    logic        w_mv_more;
    logic        w_avg_ok;
    logic [19:0] w_logx;
    logic [61:0] w_sq_prod;
    logic [31:0] w_sq;
    logic [20:0] w_y;
    logic [23:0] w_mag;
    logic [55:0] w_ln_prod;
    logic [23:0] w_lq;
    logic [13:0] w_beta1;
    logic        w_den_pos;
    logic [16:0] w_tc;
    logic        w_out_free;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign w_sum_next = r_sum + 21'(i_conv_value[15:3]);
    assign w_n        = {1'b0, r_taken} + 9'd1;
    // a count of zero acts as one
    assign w_count    = (r_count == 8'd0) ? 8'd1 : r_count;
    assign w_close    = w_n >= {1'b0, w_count};

    // restoring divider step
    assign w_rem2   = {r_rem, r_dvd[52]};
    assign w_ge     = w_rem2 >= {1'b0, r_dsr};
    assign w_remsub = w_rem2 - {1'b0, r_dsr};

    // mean saturates to the field
    assign w_avg     = (|r_dvd[52:13]) ? 13'h1FFF : r_dvd[12:0];
    assign w_mv_prod = 25'(w_avg) * 25'(ntcabt_pkg::MV_SCALE);
    assign w_avg_ok  = (r_avg != 13'd0) && (r_avg <= 13'(ntcabt_pkg::FULL_SCALE - 2));

    // divide by full scale: p/4096 * (1 + 1/4096) is low by at most one
    assign w_mv_est  = r_dvd[24:0] + {12'd0, r_dvd[24:12]};
    assign w_mv_rem  = r_dvd[24:0] - {w_mv_est[24:12], 12'd0} + {12'd0, w_mv_est[24:12]};
    assign w_mv_more = r_rem >= 38'(ntcabt_pkg::FULL_SCALE);

    // log operands: series, full scale minus mean, mean, nominal; last two subtract
    always_comb begin
        case (r_lsel)
            2'd0:    w_logx = (r_series == 20'd0) ? 20'd1 : r_series;
            2'd1:    w_logx = 20'(13'(ntcabt_pkg::FULL_SCALE) - r_avg);
            2'd2:    w_logx = 20'(r_avg);
            default: w_logx = (r_nominal == 20'd0) ? 20'd1 : r_nominal;
        endcase
    end

    // q30 mantissa squared, back to q30
    assign w_sq_prod = 62'(r_z[30:0]) * 62'(r_z[30:0]);
    assign w_sq      = w_sq_prod[61:30];
    assign w_y       = {r_p, r_frac};

    // natural log from log2, rounded, sign restored
    assign w_mag     = r_s[23] ? 24'(-r_s) : 24'(r_s);
    assign w_ln_prod = 56'(w_mag) * 56'(ntcabt_pkg::LN2_Q32) + 56'h0000_0080_0000_00;
    assign w_lq      = w_ln_prod[55:32];

    assign w_beta1   = (r_beta == 14'd0) ? 14'd1 : r_beta;
    assign w_den_pos = !r_den[39] && (r_den != 40'sd0);

    // centi-kelvin to centi-celsius; quotient below 2^16 here
    assign w_tc = {1'b0, r_dvd[15:0]} - 17'(ntcabt_pkg::ZERO_C_CENTI_K);

    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ntcabt_pkg::ST_IDLE: begin
                if (w_in_acc && w_close) begin
                    n_state = ntcabt_pkg::ST_DIV_AVG;
                end
            end
            ntcabt_pkg::ST_DIV_AVG: begin
                if (r_cnt == 6'd0) begin
                    n_state = ntcabt_pkg::ST_MV_LOAD;
                end
            end
            ntcabt_pkg::ST_MV_LOAD:  n_state = ntcabt_pkg::ST_DIV_MV;
            ntcabt_pkg::ST_DIV_MV: begin
                if (r_cnt == 6'd0 && !w_mv_more) begin
                    n_state = ntcabt_pkg::ST_CHECK;
                end
            end
            ntcabt_pkg::ST_CHECK: begin
                n_state = w_avg_ok ? ntcabt_pkg::ST_LOG_LOAD : ntcabt_pkg::ST_DONE;
            end
            ntcabt_pkg::ST_LOG_LOAD: n_state = ntcabt_pkg::ST_LOG_NORM;
            ntcabt_pkg::ST_LOG_NORM: begin
                if (r_z[31]) begin
                    n_state = ntcabt_pkg::ST_LOG_SQ;
                end
            end
            ntcabt_pkg::ST_LOG_SQ: begin
                if (r_cnt == 6'd0) begin
                    n_state = ntcabt_pkg::ST_LOG_ACC;
                end
            end
            ntcabt_pkg::ST_LOG_ACC: begin
                n_state = (r_lsel == 2'd3) ? ntcabt_pkg::ST_LN : ntcabt_pkg::ST_LOG_LOAD;
            end
            ntcabt_pkg::ST_LN:     n_state = ntcabt_pkg::ST_MUL_A;
            ntcabt_pkg::ST_MUL_A:  n_state = ntcabt_pkg::ST_MUL_B;
            ntcabt_pkg::ST_MUL_B:  n_state = ntcabt_pkg::ST_DEN;
            ntcabt_pkg::ST_DEN:    n_state = ntcabt_pkg::ST_T_LOAD;
            ntcabt_pkg::ST_T_LOAD: begin
                n_state = w_den_pos ? ntcabt_pkg::ST_DIV_T : ntcabt_pkg::ST_DONE;
            end
            ntcabt_pkg::ST_DIV_T: begin
                if (r_cnt == 6'd0) begin
                    n_state = ntcabt_pkg::ST_T_FIN;
                end
            end
            ntcabt_pkg::ST_T_FIN:  n_state = ntcabt_pkg::ST_DONE;
            ntcabt_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = ntcabt_pkg::ST_IDLE;
                end
            end
            default: n_state = ntcabt_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall  = (r_state != ntcabt_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
    end

    assign o_out_valid    = r_out_valid;
    assign o_average_raw  = r_o_avg;
    assign o_millivolts   = r_o_mv;
    assign o_temp_centi_c = r_o_temp;
    assign o_temp_valid   = r_o_tvalid;

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ntcabt_pkg::ST_IDLE;
            r_count     <= 8'd16;
            r_series    <= 20'd100;
            r_nominal   <= 20'd10000;
            r_beta      <= 14'd3950;
            r_sum       <= 21'd0;
            r_taken     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    ntcabt_pkg::CFG_SAMPLE_COUNT: r_count   <= i_cfg_data[7:0];
                    ntcabt_pkg::CFG_SERIES_OHMS:  r_series  <= i_cfg_data;
                    ntcabt_pkg::CFG_NOMINAL_OHMS: r_nominal <= i_cfg_data;
                    ntcabt_pkg::CFG_BETA_KELVIN:  r_beta    <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                if (w_close) begin
                    r_sum   <= 21'd0;
                    r_taken <= 8'd0;
                end else begin
                    r_sum   <= w_sum_next;
                    r_taken <= w_n[7:0];
                end
            end
            if (r_state == ntcabt_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ntcabt_pkg::ST_IDLE: begin
                // divide the batch sum by the number of words summed
                r_dvd <= 53'(w_sum_next);
                r_dsr <= 38'(w_n[7:0]);
                r_rem <= 38'd0;
                r_cnt <= 6'(ntcabt_pkg::DIV_STEPS - 1);
            end
            ntcabt_pkg::ST_DIV_AVG, ntcabt_pkg::ST_DIV_T: begin
                r_rem <= w_ge ? w_remsub[37:0] : w_rem2[37:0];
                r_dvd <= {r_dvd[51:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            ntcabt_pkg::ST_MV_LOAD: begin
                r_avg <= w_avg;
                r_dvd <= 53'(w_mv_prod);
                r_cnt <= 6'd1;
            end
            ntcabt_pkg::ST_DIV_MV: begin
                // first the estimate and its remainder, then one subtract if needed
                if (r_cnt != 6'd0) begin
                    r_dvd <= 53'(w_mv_est[24:12]);
                    r_rem <= 38'(w_mv_rem);
                    r_cnt <= 6'd0;
                end else if (w_mv_more) begin
                    r_dvd <= r_dvd + 53'd1;
                    r_rem <= r_rem - 38'(ntcabt_pkg::FULL_SCALE);
                end
            end
            ntcabt_pkg::ST_CHECK: begin
                r_mv     <= r_dvd[12:0];
                r_tvalid <= w_avg_ok;
                r_temp   <= 16'sd0;
                r_s      <= 24'sd0;
                r_lsel   <= 2'd0;
            end
            ntcabt_pkg::ST_LOG_LOAD: begin
                r_z <= 32'(w_logx);
                r_p <= 5'd31;
            end
            ntcabt_pkg::ST_LOG_NORM: begin
                if (r_z[31]) begin
                    r_z    <= {1'b0, r_z[31:1]};
                    r_frac <= 16'd0;
                    r_cnt  <= 6'(ntcabt_pkg::LOG_FRAC_BITS - 1);
                end else begin
                    r_z <= {r_z[30:0], 1'b0};
                    r_p <= r_p - 5'd1;
                end
            end
            ntcabt_pkg::ST_LOG_SQ: begin
                if (w_sq[31]) begin
                    r_z                 <= {1'b0, w_sq[31:1]};
                    r_frac[r_cnt[3:0]]  <= 1'b1;
                end else begin
                    r_z <= w_sq;
                end
                r_cnt <= r_cnt - 6'd1;
            end
            ntcabt_pkg::ST_LOG_ACC: begin
                r_s    <= r_lsel[1] ? r_s - $signed(24'(w_y)) : r_s + $signed(24'(w_y));
                r_lsel <= r_lsel + 2'd1;
            end
            ntcabt_pkg::ST_LN: begin
                r_lq <= r_s[23] ? -$signed(w_lq) : $signed(w_lq);
            end
            ntcabt_pkg::ST_MUL_A: begin
                r_pa <= 38'(w_beta1) * 38'(ntcabt_pkg::SCALE_Q16_X100);
                r_pb <= 29'(w_beta1) * 29'(ntcabt_pkg::T0_CENTI_K);
            end
            ntcabt_pkg::ST_MUL_B: begin
                r_pc  <= 40'(r_lq) * 40'sd29815;
                r_num <= 52'(r_pb) * 52'(ntcabt_pkg::SCALE_Q16_X100);
            end
            ntcabt_pkg::ST_DEN: begin
                r_den <= $signed({2'b00, r_pa}) + r_pc;
            end
            ntcabt_pkg::ST_T_LOAD: begin
                if (w_den_pos) begin
                    // round to nearest by adding half the denominator
                    r_dvd <= 53'(r_num) + 53'(r_den[38:1]);
                    r_dsr <= r_den[37:0];
                    r_rem <= 38'd0;
                    r_cnt <= 6'(ntcabt_pkg::DIV_STEPS - 1);
                end else begin
                    r_temp <= 16'(ntcabt_pkg::TEMP_MAX);
                end
            end
            ntcabt_pkg::ST_T_FIN: begin
                if ((|r_dvd[52:16]) ||
                    (r_dvd[15:0] > 16'(ntcabt_pkg::TEMP_MAX + ntcabt_pkg::ZERO_C_CENTI_K))) begin
                    r_temp <= 16'(ntcabt_pkg::TEMP_MAX);
                end else begin
                    r_temp <= $signed(w_tc[15:0]);
                end
            end
            ntcabt_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_o_avg    <= r_avg;
                    r_o_mv     <= r_mv;
                    r_o_temp   <= r_temp;
                    r_o_tvalid <= r_tvalid;
                end
            end
            default: ;
        endcase
    end

    // a finished batch always reaches the output register
    `ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == ntcabt_pkg::ST_DONE && w_out_free, r_out_valid)
    // the batch count never reaches the top of its range
    `ASSERT_IMPLY(a_taken_range, i_clk, i_rst_n, r_state == ntcabt_pkg::ST_IDLE, r_taken != 8'hFF)
    // squaring only ever sees a normalised mantissa
    `ASSERT_IMPLY(a_log_norm, i_clk, i_rst_n, r_state == ntcabt_pkg::ST_LOG_SQ, r_z[31:30] == 2'b01)
    // a valid temperature comes only from a mean inside the usable range
    `ASSERT_IMPLY(a_tvalid_range, i_clk, i_rst_n, r_out_valid && r_o_tvalid, (r_o_avg != 13'd0) && (r_o_avg <= 13'd4093))

endmodule

[dv/ntc_average_beta_temperature_tb.sv]
// self-checking testbench of the ntc averaging and beta temperature block
// depends on ntcabt_pkg and the rtl top level; a scoreboard class predicts every result
`timescale 1ns / 1ps

module ntc_average_beta_temperature_tb;

    // index past the last register, writes there must be dropped
    localparam logic [3:0] CFG_UNUSED_FIRST = 4'd4;
    // margin after the last reading, so wait comfortably beyond the longest closing word
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic [12:0]        avg;
        logic [12:0]        mv;
        logic signed [15:0] temp;
        logic               tvalid;
    } t_reading;

    // mirror of the block: registers, batch sum and queue of pending readings
    class batch_scoreboard;
        logic [7:0]  count_reg;
        logic [19:0] series_reg;
        logic [19:0] nominal_reg;
        logic [13:0] beta_reg;
        logic [20:0] sum;
        logic [7:0]  taken;
        t_reading    pending_q[$];

        function new();
            count_reg   = 8'd16;
            series_reg  = 20'd100;
            nominal_reg = 20'd10000;
            beta_reg    = 14'd3950;
            sum         = '0;
            taken       = '0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [19:0] data);
            case (idx)
                ntcabt_pkg::CFG_SAMPLE_COUNT: count_reg   = data[7:0];
                ntcabt_pkg::CFG_SERIES_OHMS:  series_reg  = data;
                ntcabt_pkg::CFG_NOMINAL_OHMS: nominal_reg = data;
                ntcabt_pkg::CFG_BETA_KELVIN:  beta_reg    = data[13:0];
                default: ;
            endcase
        endfunction

        // q16 log2 by truncated repeated squaring of a q30 mantissa
        function longint log2_fixed(logic [31:0] x);
            int          p;
            logic [63:0] z;
            logic [31:0] y;
            if (x == 0) x = 1;
            p = 31;
            while (x[p] == 1'b0) p--;
            if (p <= 30) z = {32'd0, x} << (30 - p);
            else z = {32'd0, x >> (p - 30)};
            y = p << 16;
            for (int b = 15; b >= 0; b--) begin
                z = (z * z) >> 30;
                if (z >= 64'h8000_0000) begin
                    z = z >> 1;
                    y[b] = 1'b1;
                end
            end
            return longint'(y);
        endfunction

        function logic signed [15:0] beta_temp(logic [12:0] avg);
            logic [31:0] rs, r0;
            longint      b, s, mag, lq, num, den, tck, tc;
            rs  = (series_reg == 0) ? 32'd1 : {12'd0, series_reg};
            r0  = (nominal_reg == 0) ? 32'd1 : {12'd0, nominal_reg};
            b   = (beta_reg == 0) ? 1 : longint'(beta_reg);
            s   = log2_fixed(rs) + log2_fixed(ntcabt_pkg::FULL_SCALE - avg)
                - log2_fixed({19'd0, avg}) - log2_fixed(r0);
            mag = (s < 0) ? -s : s;
            lq  = (mag * ntcabt_pkg::LN2_Q32 + (64'd1 << 31)) >>> 32;
            if (s < 0) lq = -lq;
            den = b * ntcabt_pkg::SCALE_Q16_X100 + longint'(ntcabt_pkg::T0_CENTI_K) * lq;
            if (den <= 0) return 16'sd32767;
            num = longint'(ntcabt_pkg::T0_CENTI_K) * b * ntcabt_pkg::SCALE_Q16_X100;
            tck = (num + den / 2) / den;
            tc  = tck - ntcabt_pkg::ZERO_C_CENTI_K;
            if (tc > ntcabt_pkg::TEMP_MAX) tc = ntcabt_pkg::TEMP_MAX;
            return tc[15:0];
        endfunction

        // one accepted converter word; queues a reading when the batch closes
        function void note_word(logic [15:0] conv);
            logic [31:0] cnt, n, avg, mv;
            t_reading    r;
            cnt = (count_reg == 0) ? 32'd1 : {24'd0, count_reg};
            sum = sum + {8'd0, conv[15:3]};
            n   = {24'd0, taken} + 1;
            if (n < cnt) begin
                taken = n[7:0];
                return;
            end
            avg = {11'd0, sum} / n;
            if (avg > 8191) avg = 8191;
            sum   = '0;
            taken = '0;
            mv = avg * ntcabt_pkg::MV_SCALE / ntcabt_pkg::FULL_SCALE;
            if (mv > 8191) mv = 8191;
            r.avg    = avg[12:0];
            r.mv     = mv[12:0];
            r.tvalid = (avg >= 1) && (avg + 2 <= ntcabt_pkg::FULL_SCALE);
            r.temp   = r.tvalid ? beta_temp(avg[12:0]) : 16'sd0;
            pending_q.push_back(r);
        endfunction

        // bit mask of wrong fields, or -1 when no reading was waiting
        function int check_reading(t_reading got);
            t_reading e;
            int       bad;
            if (pending_q.size() == 0) return -1;
            e   = pending_q.pop_front();
            bad = 0;
            if (got.avg !== e.avg)       bad |= 1;
            if (got.mv !== e.mv)         bad |= 2;
            if (got.temp !== e.temp)     bad |= 4;
            if (got.tvalid !== e.tvalid) bad |= 8;
            return bad;
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_conv_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [12:0]        o_average_raw;
    logic [12:0]        o_millivolts;
    logic signed [15:0] o_temp_centi_c;
    logic               o_temp_valid;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_index = '0;
    logic [19:0]        i_cfg_data = '0;

    ntc_average_beta_temperature u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_conv_value   (i_conv_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_average_raw  (o_average_raw),
        .o_millivolts   (o_millivolts),
        .o_temp_centi_c (o_temp_centi_c),
        .o_temp_valid   (o_temp_valid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    batch_scoreboard sb = new();

    int errors;
    int cycles;
    int words_sent;
    int readings_seen;
    int cfg_writes;
    int gap_pct;
    int stall_pct;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("ntc_average_beta_temperature_tb NOT OK");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(string msg);
        $display("mismatch @%0d: %s", cycles, msg);
        errors++;
    endtask

    // monitors sample on the rising edge, inputs are stable since the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_word(i_conv_value);
    end

    always @(posedge i_clk) begin
        int       res;
        t_reading got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_average_raw, o_millivolts, o_temp_centi_c, o_temp_valid};
            res = sb.check_reading(got);
            readings_seen++;
            if (res < 0)
                report_mismatch($sformatf("unexpected reading avg %0d", o_average_raw));
            else if (res != 0)
                report_mismatch($sformatf("fields %b wrong: avg %0d mv %0d t %0d v %0b",
                    res[3:0], o_average_raw, o_millivolts, o_temp_centi_c, o_temp_valid));
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_word(logic [15:0] v);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_conv_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_avg(int avg);
        send_word({avg[12:0], 3'($urandom_range(7))});
    endtask

    // drops input valid and lets the block finish every pending reading
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        cfg_writes++;
    endtask

    task automatic set_all(logic [19:0] cnt, logic [19:0] rs, logic [19:0] r0,
                           logic [19:0] b);
        settle();
        write_reg(ntcabt_pkg::CFG_SAMPLE_COUNT, cnt);
        write_reg(ntcabt_pkg::CFG_SERIES_OHMS, rs);
        write_reg(ntcabt_pkg::CFG_NOMINAL_OHMS, r0);
        write_reg(ntcabt_pkg::CFG_BETA_KELVIN, b);
    endtask

    function automatic logic [19:0] pick_ohms();
        case ($urandom_range(9))
            0: return 20'd0;
            1: return 20'd1;
            2: return 20'd1000000;
            3: return 20'hFFFFF;
            4, 5: return 20'($urandom_range(1, 1000));
            default: return 20'($urandom_range(1, 1000000));
        endcase
    endfunction

    function automatic logic [19:0] pick_count();
        case ($urandom_range(19))
            0: return 20'd0;
            1: return {12'($urandom), 8'd255};
            2: return 20'($urandom_range(5, 40));
            default: return {12'($urandom), 8'($urandom_range(1, 4))};
        endcase
    endfunction

    function automatic logic [19:0] pick_beta();
        case ($urandom_range(7))
            0: return 20'd0;
            1: return 20'd1;
            2: return 20'd10000;
            3: return {6'($urandom), 14'h3FFF};
            default: return 20'($urandom_range(1000, 5000));
        endcase
    endfunction

    // one run of random words under randomly chosen registers
    task automatic random_phase(int n_words);
        int left, target;
        left = n_words;
        while (left > 0) begin
            set_all(pick_count(), pick_ohms(), pick_ohms(), pick_beta());
            if ($urandom_range(9) == 0) write_reg(4'($urandom_range(CFG_UNUSED_FIRST, 15)),
                                                  20'($urandom));
            target = $urandom_range(1, 4093);
            repeat ($urandom_range(8, 24)) begin
                case ($urandom_range(9))
                    0, 1: send_word(16'($urandom));
                    2: send_avg($urandom_range(0, 1) ? 0 : $urandom_range(4094, 8191));
                    default: send_avg(target + $urandom_range(0, 4) - 2 < 1 ? 1
                                      : target + $urandom_range(0, 4) - 2);
                endcase
                left--;
            end
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        words_sent = 0;
        readings_seen = 0;
        cfg_writes = 0;
        gap_pct = 0;
        stall_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults first: one batch of sixteen words
        repeat (16) send_avg(2048);

        // one word per reading, across the edges of the average
        set_all(20'd1, 20'd10000, 20'd10000, 20'd3950);
        send_word(16'h0000);
        send_word(16'h0007);
        send_word(16'hFFFF);
        send_avg(1);
        send_avg(4093);
        send_avg(4094);
        send_avg(4095);
        send_avg(2048);

        // count of zero behaves as one, zero ohms and beta behave as one
        set_all(20'd0, 20'd0, 20'd0, 20'd0);
        send_avg(100);
        send_avg(3000);

        // denominator driven negative, then very cold readings
        set_all(20'd1, 20'd1, 20'd1000000, 20'd1);
        send_avg(4093);
        set_all(20'd1, 20'd1000000, 20'd1, 20'd10000);
        send_avg(1);
        send_avg(2);

        // ignored register index leaves the count alone
        settle();
        write_reg(CFG_UNUSED_FIRST, 20'd7);
        write_reg(4'd15, 20'hFFFFF);
        send_avg(50);

        // count lowered mid-batch: five summed, then the next closes at six
        set_all(20'd8, 20'd100, 20'd10000, 20'd3950);
        repeat (5) send_avg(1000);
        settle();
        write_reg(ntcabt_pkg::CFG_SAMPLE_COUNT, 20'd3);
        send_avg(1200);

        // random traffic under three idling profiles
        gap_pct = 8;
        stall_pct = 48;
        random_phase(480);
        gap_pct = 48;
        stall_pct = 8;
        random_phase(480);
        gap_pct = 0;
        stall_pct = 0;
        random_phase(490);

        settle();
        if (sb.pending_q.size() != 0)
            report_mismatch($sformatf("%0d readings never arrived", sb.pending_q.size()));

        $display("covered %0d converter words, %0d readings, %0d register writes",
                 words_sent, readings_seen, cfg_writes);
        $display("three idling profiles, edge averages and saturation cases, %0d errors",
                 errors);
        if (errors == 0) begin
            $display("ntc_average_beta_temperature_tb OK");
        end else begin
            $display("ntc_average_beta_temperature_tb NOT OK");
        end
        $finish;
    end

endmodule
